// ===== rtl/rde_pkg.sv =====
// Package for the radix digit emitter: shared constants, register codes and the
// back-end state type. No dependencies.
package rde_pkg;

  // Character and configuration widths.
  localparam int CHAR_W     = 8;
  localparam int CFG_W      = 64;
  localparam int LEN_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int NUM_DIGITS = 16;
  localparam int ALPHA_W    = NUM_DIGITS * CHAR_W;
  localparam int DIGIT_W    = 4;

  // Largest radix the alphabet may define.
  localparam logic [LEN_W-1:0] MAX_RADIX = 5'd16;

  // Reserved characters.
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_NONE  = 8'h00;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_LEN   = 2'd2;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_SIGN,
    BK_READ,
    BK_LOAD,
    BK_ERR
  } back_state_t;

endpackage

// ===== rtl/rde_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module rde_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/rde_queue.sv =====
// Small register queue that decouples the front end from the back end.
// No dependencies.
module rde_queue #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt;
  logic [PW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slot_r[rptr_r];

  // Pointer and fill-count update.
  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/rde_front.sv =====
// Front end: accepts a number, checks the alphabet and splits sign and magnitude.
// Depends on rde_pkg.
module rde_front
  import rde_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          in_push,
  input  logic signed [VALUE_WIDTH-1:0] in_number,
  input  logic                          q_full,
  input  logic [ALPHA_W-1:0]            alphabet,
  input  logic [LEN_W-1:0]              base_length,
  output logic                          q_push,
  output logic [VALUE_WIDTH+1:0]        q_data
);

  logic                   alpha_ok;
  logic                   negative;
  logic [VALUE_WIDTH-1:0] num_u;
  logic [VALUE_WIDTH-1:0] magnitude;

  // Alphabet check: length in range, characters legal and pairwise distinct.
  always_comb begin
    logic [CHAR_W-1:0] c;
    alpha_ok = (base_length >= 5'd2) && (base_length <= MAX_RADIX);
    for (int a = 0; a < NUM_DIGITS; a++) begin
      c = alphabet[a*CHAR_W +: CHAR_W];
      if (LEN_W'(a) < base_length) begin
        if (c == CH_NONE || c == CH_MINUS || c == CH_PLUS) begin
          alpha_ok = 1'b0;
        end
        for (int b = a + 1; b < NUM_DIGITS; b++) begin
          if ((LEN_W'(b) < base_length) && (alphabet[b*CHAR_W +: CHAR_W] == c)) begin
            alpha_ok = 1'b0;
          end
        end
      end
    end
  end

  // Sign and unsigned magnitude; the most negative value maps onto itself.
  assign num_u     = in_number;
  assign negative  = num_u[VALUE_WIDTH-1];
  assign magnitude = negative ? (~num_u + 1'b1) : num_u;

  // Queue entry: error flag, sign flag, magnitude.
  assign q_push = in_push && !q_full;
  assign q_data = {!alpha_ok, negative, magnitude};

endmodule

// ===== rtl/rde_back.sv =====
// Back end: divides the magnitude into digits, stores them, then emits the
// characters most significant first. Depends on rde_pkg and rde_ram.
module rde_back
  import rde_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_empty,
  input  logic [VALUE_WIDTH+1:0] q_data,
  output logic                   q_pop,
  input  logic [ALPHA_W-1:0]     alphabet,
  input  logic [LEN_W-1:0]       base_length,
  output logic                   out_empty,
  input  logic                   out_pop,
  output logic [CHAR_W-1:0]      out_character,
  output logic                   out_status,
  output logic                   out_last
);

  // Eight restoring-division steps per cycle over a zero-padded dividend.
  localparam int STEPS  = 8;
  localparam int NCHUNK = (VALUE_WIDTH + STEPS - 1) / STEPS;
  localparam int PADW   = NCHUNK * STEPS;
  localparam int IW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int AW     = $clog2(VALUE_WIDTH);
  localparam int CW     = $clog2(VALUE_WIDTH + 1);

  back_state_t       state_r, state_nxt;
  logic [PADW-1:0]   div_r, div_nxt;
  logic [DIGIT_W-1:0] rem_r, rem_nxt;
  logic [IW-1:0]     iter_r;
  logic [CW-1:0]     cnt_r;
  logic              neg_r;
  logic              last_chunk;

  logic              out_valid_r;
  logic [CHAR_W-1:0] out_char_r;
  logic              out_status_r;
  logic              out_last_r;

  logic              slot_free;
  logic              out_load;
  logic [CHAR_W-1:0] load_char;
  logic              load_status;
  logic              load_last;
  logic              ram_we;
  logic              ram_re;
  logic [DIGIT_W-1:0] ram_q;
  logic              q_err;
  logic              q_neg;
  logic [VALUE_WIDTH-1:0] q_mag;

  assign {q_err, q_neg, q_mag} = q_data;
  assign last_chunk = (iter_r == IW'(NCHUNK - 1));
  assign slot_free  = !out_valid_r || out_pop;

  // One chunk of restoring division by the radix.
  always_comb begin
    logic [DIGIT_W:0] t;
    rem_nxt = rem_r;
    div_nxt = div_r;
    for (int k = 0; k < STEPS; k++) begin
      t       = {rem_nxt, div_nxt[PADW-1]};
      div_nxt = {div_nxt[PADW-2:0], 1'b0};
      if (t >= base_length) begin
        rem_nxt    = DIGIT_W'(t - base_length);
        div_nxt[0] = 1'b1;
      end else begin
        rem_nxt = t[DIGIT_W-1:0];
      end
    end
  end

  // Digit store.
  rde_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (VALUE_WIDTH)
  ) u_digits (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (rem_nxt),
    .re    (ram_re),
    .raddr (AW'(cnt_r - 1'b1)),
    .rdata (ram_q)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          state_nxt = q_err ? BK_ERR : BK_DIV;
        end
      end
      BK_DIV: begin
        if (last_chunk && (div_nxt == '0)) begin
          state_nxt = neg_r ? BK_SIGN : BK_READ;
        end
      end
      BK_SIGN: begin
        if (slot_free) begin
          state_nxt = BK_READ;
        end
      end
      BK_READ: begin
        state_nxt = BK_LOAD;
      end
      BK_LOAD: begin
        if (slot_free) begin
          state_nxt = (cnt_r == '0) ? BK_IDLE : BK_READ;
        end
      end
      BK_ERR: begin
        if (slot_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    q_pop       = (state_r == BK_IDLE) && !q_empty;
    ram_we      = (state_r == BK_DIV) && last_chunk;
    ram_re      = (state_r == BK_READ);
    out_load    = slot_free &&
                  ((state_r == BK_SIGN) || (state_r == BK_LOAD) || (state_r == BK_ERR));
    load_status = (state_r == BK_ERR);
    load_last   = (state_r == BK_ERR) || ((state_r == BK_LOAD) && (cnt_r == '0));
    unique case (state_r)
      BK_SIGN: load_char = CH_MINUS;
      BK_ERR:  load_char = CH_NONE;
      default: load_char = alphabet[{ram_q, 3'b000} +: CHAR_W];
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      iter_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (q_pop) begin
        iter_r <= '0;
        cnt_r  <= '0;
      end else if (state_r == BK_DIV) begin
        iter_r <= last_chunk ? '0 : iter_r + 1'b1;
        if (last_chunk) begin
          cnt_r <= cnt_r + 1'b1;
        end
      end else if (ram_re) begin
        cnt_r <= cnt_r - 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      div_r <= PADW'(q_mag);
      rem_r <= '0;
      neg_r <= q_neg;
    end else if (state_r == BK_DIV) begin
      div_r <= div_nxt;
      rem_r <= last_chunk ? '0 : rem_nxt;
    end
    if (out_load) begin
      out_char_r   <= load_char;
      out_status_r <= load_status;
      out_last_r   <= load_last;
    end
  end

  assign out_empty     = !out_valid_r;
  assign out_character = out_char_r;
  assign out_status    = out_status_r;
  assign out_last      = out_last_r;

endmodule

// ===== rtl/radix_digit_emitter.sv =====
// Radix digit emitter top: rde_front, rde_queue and rde_back with rde_ram, on rde_pkg.
// Each digit comes from a chunked restoring division by the radix; the stored digits are
// then read back and emitted most significant first, after a minus sign when negative.
// The back end works on one number at a time (up to 32 digits in binary); an invalid
// alphabet yields one error character. Two queue slots in front take numbers meanwhile.
// Reset (rst_n low, synchronous) empties queue and output and clears the config registers.
module radix_digit_emitter
  import rde_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic signed [VALUE_WIDTH-1:0] in_number,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [CHAR_W-1:0]             out_character,
  output logic                          out_status,
  output logic                          out_last,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_data
);

  localparam int QW = VALUE_WIDTH + 2;

  logic [CFG_W-1:0] alpha_low_r;
  logic [CFG_W-1:0] alpha_high_r;
  logic [LEN_W-1:0] base_len_r;
  logic [ALPHA_W-1:0] alphabet;

  logic          q_push, q_full, q_pop, q_empty;
  logic [QW-1:0] q_wdata, q_rdata;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_low_r  <= '0;
      alpha_high_r <= '0;
      base_len_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ALPHA_LOW:  alpha_low_r  <= cfg_data;
        CFG_ALPHA_HIGH: alpha_high_r <= cfg_data;
        CFG_BASE_LEN:   base_len_r   <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign alphabet = {alpha_high_r, alpha_low_r};
  assign in_full  = q_full;

  // Front end: classification of each incoming number.
  rde_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .in_push     (in_push),
    .in_number   (in_number),
    .q_full      (q_full),
    .alphabet    (alphabet),
    .base_length (base_len_r),
    .q_push      (q_push),
    .q_data      (q_wdata)
  );

  // Work queue between front and back.
  rde_queue #(
    .WIDTH (QW),
    .DEPTH (2)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  // Back end: digit generation and character output.
  rde_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_data        (q_rdata),
    .q_pop         (q_pop),
    .alphabet      (alphabet),
    .base_length   (base_len_r),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_character (out_character),
    .out_status    (out_status),
    .out_last      (out_last)
  );

endmodule

// ===== tb/sv/rde_checker.sv =====
// Scoreboard for the radix digit emitter: mirrors the configuration writes, predicts the
// characters of every accepted number and compares each popped result with them.
// Depends on rde_pkg for widths, reserved characters and register indexes.
module rde_checker
  import rde_pkg::*;
#(
  parameter int VALUE_W = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  logic                 in_full,
  input  logic [VALUE_W-1:0]   in_number,
  input  logic                 out_empty,
  input  logic                 out_pop,
  input  logic [CHAR_W-1:0]    out_character,
  input  logic                 out_status,
  input  logic                 out_last,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   fail_count,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_BAD_BASE = 1'b1;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              status;
    logic              last;
  } emitted_t;

  // Characters still owed by the block, oldest first.
  emitted_t chars_due[$];

  // Local copy of the configuration registers.
  logic [ALPHA_W-1:0] alphabet;
  logic [LEN_W-1:0]   radix_len;

  function automatic logic [CHAR_W-1:0] glyph(input int idx);
    return alphabet[idx*CHAR_W +: CHAR_W];
  endfunction

  // The alphabet is usable when its length is a legal radix and its characters in use
  // are nonzero, not a sign character and all distinct.
  function automatic bit alphabet_valid();
    logic [CHAR_W-1:0] c;
    if (radix_len < 2 || radix_len > MAX_RADIX) return 1'b0;
    for (int a = 0; a < radix_len; a++) begin
      c = glyph(a);
      if (c == CH_NONE || c == CH_MINUS || c == CH_PLUS) return 1'b0;
      for (int b = a + 1; b < radix_len; b++) begin
        if (glyph(b) == c) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Queues the characters that one number turns into: an optional minus sign, then the
  // digits of the unsigned magnitude, most significant first.
  function automatic void expand_number(input logic [VALUE_W-1:0] value);
    logic [VALUE_W-1:0] magnitude;
    logic [VALUE_W-1:0] radix;
    logic [DIGIT_W-1:0] digits[VALUE_W];
    int                 count;
    emitted_t           item;
    if (!alphabet_valid()) begin
      item = '{character: CH_NONE, status: STATUS_BAD_BASE, last: 1'b1};
      chars_due.push_back(item);
      return;
    end
    radix     = VALUE_W'(radix_len);
    magnitude = value[VALUE_W-1] ? -value : value;
    count     = 0;
    do begin
      digits[count] = DIGIT_W'(magnitude % radix);
      count++;
      magnitude = magnitude / radix;
    end while (magnitude != 0);
    if (value[VALUE_W-1]) begin
      item = '{character: CH_MINUS, status: STATUS_OK, last: 1'b0};
      chars_due.push_back(item);
    end
    while (count > 0) begin
      count--;
      item = '{character: glyph(int'(digits[count])), status: STATUS_OK, last: count == 0};
      chars_due.push_back(item);
    end
  endfunction

  // Follow every transaction on the three ports at the clock edge that completes it.
  always @(posedge clk) begin
    emitted_t want;
    if (!rst_n) begin
      chars_due.delete();
      alphabet  = '0;
      radix_len = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ALPHA_LOW:  alphabet[CFG_W-1:0]       = cfg_data;
          CFG_ALPHA_HIGH: alphabet[ALPHA_W-1:CFG_W] = cfg_data;
          CFG_BASE_LEN:   radix_len                 = cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
      if (out_pop && !out_empty) begin
        if (chars_due.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual char %h status %b last %b",
                   $time, out_character, out_status, out_last);
          fail_count++;
        end else begin
          want = chars_due.pop_front();
          if (want.character !== out_character || want.status !== out_status ||
              want.last !== out_last) begin
            $display("%0t: result mismatch: expected char %h status %b last %b, actual char %h status %b last %b",
                     $time, want.character, want.status, want.last,
                     out_character, out_status, out_last);
            fail_count++;
          end
        end
      end
      if (in_push && !in_full) expand_number(in_number);
    end
    pending = chars_due.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the radix digit emitter testbench: clock, reset, configuration and number
// stimulus with random stalls on both sides, and the final verdict.
// Depends on rde_pkg, radix_digit_emitter and rde_checker.
module testbench
  import rde_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VALUE_W     = 32;
  localparam int HOLD_CYCLES = 400;
  localparam int END_CYCLES  = 60;

  logic                 clk   = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_push = 1'b0;
  logic                 in_full;
  logic [VALUE_W-1:0]   in_number = '0;
  logic                 out_empty;
  logic                 out_pop = 1'b0;
  logic [CHAR_W-1:0]    out_character;
  logic                 out_status;
  logic                 out_last;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ALPHA_LOW;
  logic [CFG_W-1:0]     cfg_data = '0;

  int fail_count;
  int pending;

  // Knobs shared between the stimulus and the result-side process.
  bit tx_idle_on  = 1'b1;
  bit rx_idle_on  = 1'b1;
  bit quiet       = 1'b0;
  bit hold_armed  = 1'b0;

  always #5 clk = ~clk;

  radix_digit_emitter #(.VALUE_WIDTH(VALUE_W)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_number(in_number),
    .out_empty(out_empty), .out_pop(out_pop), .out_character(out_character),
    .out_status(out_status), .out_last(out_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  rde_checker #(.VALUE_W(VALUE_W)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_number(in_number),
    .out_empty(out_empty), .out_pop(out_pop), .out_character(out_character),
    .out_status(out_status), .out_last(out_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  // Result side: pops freely, with random stall bursts and an occasional long hold-off.
  initial begin
    int stall;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_armed) begin
        hold_armed = 1'b0;
        stall = HOLD_CYCLES;
      end else if (rx_idle_on && !quiet && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 18);
      end else begin
        stall = 0;
      end
      if (stall > 0) begin
        out_pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end else begin
        out_pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offers one number and returns at the edge where the transaction completes. The push
  // stays high on return so back-to-back numbers need no extra assignment.
  task automatic send_number(input logic [VALUE_W-1:0] value);
    int gap;
    if (tx_idle_on && !quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push   <= 1'b1;
    in_number <= value;
    @(negedge clk);
    while (in_full) @(negedge clk);
    @(posedge clk);
  endtask

  // Stops offering numbers and waits until every predicted character has been popped.
  task automatic drain();
    in_push <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Writes all three registers; only called while the block is idle.
  task automatic load_alphabet(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                               input logic [LEN_W-1:0] len);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ALPHA_LOW;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_index <= CFG_ALPHA_HIGH;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_index <= CFG_BASE_LEN;
    cfg_data  <= CFG_W'(len);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Builds a random alphabet, mostly valid; about one in six is broken in one way.
  task automatic pick_alphabet(output logic [CFG_W-1:0] lo, output logic [CFG_W-1:0] hi,
                               output logic [LEN_W-1:0] len);
    logic [CHAR_W-1:0] glyphs[NUM_DIGITS];
    logic [CHAR_W-1:0] c;
    bit                clash;
    int                spot;
    case ($urandom_range(0, 9))
      0:       len = LEN_W'(2);
      1:       len = MAX_RADIX;
      default: len = LEN_W'($urandom_range(2, 16));
    endcase
    // Bytes past the length are left as junk.
    for (int i = 0; i < NUM_DIGITS; i++) glyphs[i] = CHAR_W'($urandom_range(0, 255));
    for (int i = 0; i < len; i++) begin
      do begin
        c = CHAR_W'($urandom_range(1, 255));
        clash = (c == CH_MINUS) || (c == CH_PLUS);
        for (int j = 0; j < i; j++) clash |= (glyphs[j] == c);
      end while (clash);
      glyphs[i] = c;
    end
    if ($urandom_range(0, 5) == 0) begin
      spot = $urandom_range(1, len - 1);
      case ($urandom_range(0, 4))
        0: glyphs[spot] = CH_NONE;
        1: glyphs[spot] = CH_MINUS;
        2: glyphs[$urandom_range(0, len - 1)] = CH_PLUS;
        3: glyphs[spot] = glyphs[$urandom_range(0, spot - 1)];
        default: len = ($urandom_range(0, 1) == 0) ? LEN_W'($urandom_range(0, 1))
                                                   : LEN_W'($urandom_range(17, 31));
      endcase
    end
    for (int k = 0; k < 8; k++) begin
      lo[k*CHAR_W +: CHAR_W] = glyphs[k];
      hi[k*CHAR_W +: CHAR_W] = glyphs[k + 8];
    end
  endtask

  // Random numbers: full-range values, short values of either sign and the extremes.
  function automatic logic [VALUE_W-1:0] pick_number();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 7))
      3:       v = $urandom >> $urandom_range(0, 31);
      4:       v = -($urandom >> $urandom_range(0, 31));
      5:       v = VALUE_W'($urandom_range(0, 40));
      6:       v = -VALUE_W'($urandom_range(1, 40));
      7: begin
        case ($urandom_range(0, 4))
          0:       v = '0;
          1:       v = {1'b1, {(VALUE_W-1){1'b0}}};
          2:       v = {1'b0, {(VALUE_W-1){1'b1}}};
          3:       v = '1;
          default: v = VALUE_W'(1);
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic random_phase(input int count);
    logic [CFG_W-1:0] lo;
    logic [CFG_W-1:0] hi;
    logic [LEN_W-1:0] len;
    pick_alphabet(lo, hi, len);
    load_alphabet(lo, hi, len);
    for (int i = 0; i < count; i++) send_number(pick_number());
    drain();
  endtask

  // Main stimulus sequence.
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers still at reset: a zero-length alphabet reports an error.
    send_number('0);
    send_number('1);
    drain();

    // Decimal: zero, ones, both extremes and a long value.
    load_alphabet("76543210", "98", LEN_W'(10));
    send_number('0);
    send_number(VALUE_W'(1));
    send_number('1);
    send_number(32'h7FFF_FFFF);
    send_number(32'h8000_0000);
    send_number(-VALUE_W'(10));
    send_number(VALUE_W'(1_000_000_000));
    drain();

    // Binary gives the longest outputs; the most negative value yields a sign and 32 digits.
    load_alphabet("76543210", '0, LEN_W'(2));
    send_number(32'h8000_0000);
    send_number(32'h7FFF_FFFF);
    send_number('1);
    send_number('0);
    drain();

    // Full sixteen-character alphabet.
    load_alphabet("76543210", "FEDCBA98", MAX_RADIX);
    send_number(32'hDEAD_BEEF);
    send_number(32'h8000_0000);
    send_number(VALUE_W'(15));
    send_number(VALUE_W'(16));
    drain();

    // Length one, lengths above the maximum, and bad characters in use.
    load_alphabet("76543210", "FEDCBA98", LEN_W'(1));
    send_number(VALUE_W'(5));
    drain();
    load_alphabet("76543210", "FEDCBA98", LEN_W'(17));
    send_number(VALUE_W'(5));
    drain();
    load_alphabet("76543210", "FEDCBA98", LEN_W'(31));
    send_number(VALUE_W'(5));
    drain();
    load_alphabet("76543210", 64'h4645_4443_0041_3938, MAX_RADIX);
    send_number(VALUE_W'(5));
    drain();
    load_alphabet("765-3210", "98", LEN_W'(10));
    send_number(VALUE_W'(5));
    drain();
    load_alphabet("76543+10", '0, LEN_W'(8));
    send_number(VALUE_W'(5));
    drain();
    load_alphabet("76543210", "0EDCBA98", MAX_RADIX);
    send_number(VALUE_W'(5));
    drain();

    // A sign character past the length is ignored.
    load_alphabet("-cba", '0, LEN_W'(3));
    send_number(-VALUE_W'(100));
    drain();

    // Random phases with varying stalls; two of them hold the result side off for long.
    for (int p = 0; p < 8; p++) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      if (p == 1 || p == 5) hold_armed = 1'b1;
      random_phase($urandom_range(36, 44));
    end

    // Closing stretch at full rate on both sides.
    quiet = 1'b1;
    random_phase(30);

    repeat (END_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #30_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
